// ===== sv/rrd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared types and codes for the relocation record decoder: channel payloads,
// configuration set, action, status and register index codes.
// ----------------------------------------------------------------------------
package rrd_pkg;

  // Import table geometry
  localparam int IMPORT_DEPTH = 256;
  localparam int IMPORT_AW    = 8;

  // Configuration port
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 32;

  localparam logic [CFG_IW-1:0] REG_DATA_ADDRESS   = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SYMBOL_ADDRESS = 3'd1;
  localparam logic [CFG_IW-1:0] REG_CODE_ADDRESS   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SECTION_BASE   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_IMPORT_COUNT   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_RECORD_COUNT   = 3'd5;

  // Input actions
  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_IMPORT  = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_SECTION = 3'd1;
  localparam logic [2:0] ST_BAD_SYMBOL  = 3'd2;
  localparam logic [2:0] ST_BAD_KIND    = 3'd3;
  localparam logic [2:0] ST_BAD_TYPE    = 3'd4;

  // Patch width codes
  localparam logic [1:0] PW_8  = 2'd0;
  localparam logic [1:0] PW_16 = 2'd1;
  localparam logic [1:0] PW_32 = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  stream_byte;
    logic [7:0]  import_slot;
    logic [31:0] import_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] patch_offset;
    logic [1:0]  patch_width;
    logic [31:0] patch_addend;
    logic [2:0]  status;
    logic        last_record;
  } out_item_t;

  typedef struct packed {
    logic [31:0] data_address;
    logic [31:0] symbol_address;
    logic [31:0] code_address;
    logic [31:0] section_base;
    logic [8:0]  import_count;
    logic [15:0] record_count;
  } cfg_t;

endpackage

// ===== sv/rrd_parser.sv =====
// ----------------------------------------------------------------------------
// rrd_parser
// Record stream parser: takes one input item per cycle, advances the parser
// state, holds the import table and produces at most one patch result.
// ----------------------------------------------------------------------------
module rrd_parser import rrd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      take_valid,
  input  in_item_t  take_item,
  output logic      res_valid,
  output out_item_t res_item
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_ITEM1  = 3'd1;
  localparam logic [2:0] PH_ITEM2  = 3'd2;
  localparam logic [2:0] PH_ITEM3  = 3'd3;
  localparam logic [2:0] PH_ITEM4  = 3'd4;
  localparam logic [2:0] PH_DELTA  = 3'd5;

  localparam logic [1:0] KIND_SECTION = 2'd1;
  localparam logic [1:0] KIND_IMPORT  = 2'd2;

  // Parser state
  logic [2:0]  phase, phase_next;
  logic [7:0]  header, header_next;
  logic [28:0] item_acc, item_acc_next;
  logic [1:0]  bytes_left, bytes_left_next;
  logic [31:0] delta_acc, delta_next;
  logic [31:0] run_loc, loc_next;
  logic [15:0] rec_done, rec_next;
  logic [31:0] target, target_next;
  logic        tgt_mem, tgt_mem_next;
  logic        halted, halted_next;

  // Import table
  logic [31:0] import_mem [IMPORT_DEPTH];
  logic [31:0] mem_rdata;
  logic        mem_we, mem_re;
  logic [IMPORT_AW-1:0] mem_raddr;

  // Datapath helpers
  logic [7:0]  b;
  logic [28:0] shifted, item_full, item_m1;
  logic [31:0] delta_full, lane_val, loc_sum, tgt_sel, addend_raw, addend;
  logic [1:0]  lane;
  logic [3:0]  rtype;
  logic [1:0]  kind, wcode;
  logic [15:0] rec_inc;
  logic        resolve, finish, err, clear;
  logic [2:0]  err_code;

  assign b         = take_item.stream_byte;
  assign shifted   = {item_acc[20:0], b};
  assign kind      = header[3:2];
  assign rtype     = header[7:4];
  assign item_m1   = item_full - 29'd1;
  assign mem_raddr = item_m1[IMPORT_AW-1:0];
  assign lane      = header[1:0] - bytes_left;
  assign lane_val  = {24'd0, b} << {lane, 3'b000};
  assign tgt_sel   = tgt_mem ? mem_rdata : target;
  assign loc_sum   = run_loc + delta_full;
  assign addend_raw = rtype[0] ? (tgt_sel - (loc_sum + cfg.section_base)) : tgt_sel;
  assign wcode     = 2'((rtype - 4'd4) >> 1);
  assign rec_inc   = rec_done + 16'd1;

  // Patch value truncated to its width
  always_comb begin
    case (wcode)
      PW_8:    addend = {24'd0, addend_raw[7:0]};
      PW_16:   addend = {16'd0, addend_raw[15:0]};
      default: addend = addend_raw;
    endcase
  end

  // Next state and result
  always_comb begin
    phase_next      = phase;
    header_next     = header;
    item_acc_next   = item_acc;
    bytes_left_next = bytes_left;
    delta_next      = delta_acc;
    loc_next        = run_loc;
    rec_next        = rec_done;
    target_next     = target;
    tgt_mem_next    = tgt_mem;
    halted_next     = halted;
    res_valid       = 1'b0;
    res_item        = '0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    item_full       = '0;
    delta_full      = delta_acc;
    resolve         = 1'b0;
    finish          = 1'b0;
    err             = 1'b0;
    err_code        = ST_OK;
    clear           = 1'b0;

    if (take_valid) begin
      case (take_item.action)
        ACT_BYTE: begin
          if (!halted && (rec_done < cfg.record_count)) begin
            case (phase)
              PH_HEADER: begin
                header_next = b;
                phase_next  = PH_ITEM1;
              end
              PH_ITEM1: begin
                if (b[7]) begin
                  item_acc_next = {22'd0, b[6:0]};
                  phase_next    = PH_ITEM2;
                end else begin
                  item_full = {21'd0, b};
                  resolve   = 1'b1;
                end
              end
              PH_ITEM2: begin
                item_full = shifted;
                if (shifted[14]) begin
                  item_acc_next = {15'd0, shifted[13:0]};
                  phase_next    = PH_ITEM3;
                end else begin
                  resolve = 1'b1;
                end
              end
              PH_ITEM3: begin
                item_full = shifted;
                if (shifted[21]) begin
                  item_acc_next = {8'd0, shifted[20:0]};
                  phase_next    = PH_ITEM4;
                end else begin
                  resolve = 1'b1;
                end
              end
              PH_ITEM4: begin
                item_full = shifted;
                resolve   = 1'b1;
              end
              PH_DELTA: begin
                delta_full = delta_acc | lane_val;
                if (bytes_left == 2'd0) begin
                  finish = 1'b1;
                end else begin
                  delta_next      = delta_full;
                  bytes_left_next = bytes_left - 2'd1;
                end
              end
              default: clear = 1'b1;
            endcase
          end
        end
        ACT_IMPORT: mem_we = 1'b1;
        ACT_RESTART: begin
          clear       = 1'b1;
          loc_next    = '0;
          rec_next    = '0;
          halted_next = 1'b0;
        end
        default: ;
      endcase
    end

    // Item number complete: pick the target or flag it
    if (resolve) begin
      case (kind)
        KIND_SECTION: begin
          tgt_mem_next = 1'b0;
          if (item_full == 29'd1) begin
            target_next = cfg.data_address;
          end else if (item_full == 29'd2) begin
            target_next = cfg.symbol_address;
          end else if (item_full == 29'd3) begin
            target_next = cfg.code_address;
          end else begin
            err      = 1'b1;
            err_code = ST_BAD_SECTION;
          end
        end
        KIND_IMPORT: begin
          if ((item_full == 29'd0) || (item_full > {20'd0, cfg.import_count}) ||
              (item_full > 29'(IMPORT_DEPTH))) begin
            err      = 1'b1;
            err_code = ST_BAD_SYMBOL;
          end else begin
            mem_re       = 1'b1;
            tgt_mem_next = 1'b1;
          end
        end
        default: begin
          err      = 1'b1;
          err_code = ST_BAD_KIND;
        end
      endcase
      if (!err) begin
        phase_next      = PH_DELTA;
        bytes_left_next = header[1:0];
        delta_next      = '0;
      end
    end

    // Delta complete: advance location and emit the patch, or flag a bad type
    if (finish) begin
      loc_next = loc_sum;
      if ((rtype < 4'd4) || (rtype > 4'd9)) begin
        err      = 1'b1;
        err_code = ST_BAD_TYPE;
      end else begin
        rec_next                = rec_inc;
        res_valid               = 1'b1;
        res_item.patch_offset   = loc_sum;
        res_item.patch_width    = wcode;
        res_item.patch_addend   = addend;
        res_item.status         = ST_OK;
        res_item.last_record    = (rec_inc >= cfg.record_count);
        clear                   = 1'b1;
      end
    end

    // Error result halts until restart
    if (err) begin
      res_valid            = 1'b1;
      res_item             = '0;
      res_item.status      = err_code;
      res_item.last_record = 1'b1;
      halted_next          = 1'b1;
      clear                = 1'b1;
    end

    if (clear) begin
      phase_next      = PH_HEADER;
      header_next     = '0;
      item_acc_next   = '0;
      bytes_left_next = '0;
      delta_next      = '0;
      target_next     = '0;
      tgt_mem_next    = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      header     <= '0;
      item_acc   <= '0;
      bytes_left <= '0;
      delta_acc  <= '0;
      run_loc    <= '0;
      rec_done   <= '0;
      target     <= '0;
      tgt_mem    <= 1'b0;
      halted     <= 1'b0;
    end else begin
      phase      <= phase_next;
      header     <= header_next;
      item_acc   <= item_acc_next;
      bytes_left <= bytes_left_next;
      delta_acc  <= delta_next;
      run_loc    <= loc_next;
      rec_done   <= rec_next;
      target     <= target_next;
      tgt_mem    <= tgt_mem_next;
      halted     <= halted_next;
    end
  end

  // Import table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      import_mem[take_item.import_slot[IMPORT_AW-1:0]] <= take_item.import_value;
    end
    if (mem_re) begin
      mem_rdata <= import_mem[mem_raddr];
    end
  end

  // Halted parser never produces an ok patch
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (halted && take_valid && take_item.action == ACT_BYTE) |-> !res_valid)
    else $error("result produced while halted");

  // Import read is only issued on a symbol item
  a_read_kind: assert property (@(posedge clk) disable iff (rst)
    mem_re |-> (resolve && kind == KIND_IMPORT))
    else $error("import read outside symbol resolve");

  // Table value is selected only while a delta is being collected
  a_mem_sel: assert property (@(posedge clk) disable iff (rst)
    tgt_mem |-> (phase == PH_DELTA))
    else $error("import target held outside delta phase");

endmodule

// ===== sv/relocation_record_decoder_top.sv =====
// ----------------------------------------------------------------------------
// relocation_record_decoder_top
// Relocation record decoder: byte stream of records in, patch commands out.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall/item) carries stream bytes, import
// table loads and section restarts. Output channel (result_valid/
// result_stall/result) carries one patch command per completed record, or
// an error result after which record bytes are ignored until a restart.
// The user writes configuration registers via cfg_write/cfg_index/cfg_data
// only while the block is idle (not enforced); they take effect at once.
// An item is captured in the input register at its transfer, and its result,
// if any, passes from there through the parser into the output buffer.
// Throughput: one item per cycle unless stalled; each byte advances the parser
// in one pass of logic from the input register into the output buffer.
// The output buffer holds two results. item_stall is high while the skid
// entry is full, or while the receiver stalls a waiting result with an item
// in flight; it drops in the cycle after the skid entry moves on.
// Reset (rst, synchronous) clears parser state, counters, the buffer and the
// configuration registers; the import table holds no value until loaded.
// ----------------------------------------------------------------------------
module relocation_record_decoder_top import rrd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  in_item_t          item,
  output logic              result_valid,
  input  logic              result_stall,
  output out_item_t         result,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      res_valid;
  out_item_t res_item;
  logic      skid_valid;
  out_item_t skid_item;
  logic      out_take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DATA_ADDRESS:   cfg.data_address   <= cfg_data;
        REG_SYMBOL_ADDRESS: cfg.symbol_address <= cfg_data;
        REG_CODE_ADDRESS:   cfg.code_address   <= cfg_data;
        REG_SECTION_BASE:   cfg.section_base   <= cfg_data;
        REG_IMPORT_COUNT:   cfg.import_count   <= cfg_data[8:0];
        REG_RECORD_COUNT:   cfg.record_count   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Stall when the skid entry is full, or a held result meets an item in flight
  assign item_stall = skid_valid || (result_valid && result_stall && s1_valid);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= item_valid && !item_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  rrd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .take_valid (s1_valid),
    .take_item  (s1_item),
    .res_valid  (res_valid),
    .res_item   (res_item)
  );

  // Output register plus skid entry
  assign out_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_take || !result_valid) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= res_valid;
      end else begin
        result_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !result_valid) begin
      if (skid_valid) begin
        result <= skid_item;
        if (res_valid) begin
          skid_item <= res_item;
        end
      end else if (res_valid) begin
        result <= res_item;
      end
    end else if (res_valid) begin
      skid_item <= res_item;
    end
  end

  // Skid entry only fills behind a waiting result
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry without output entry");

  // A full buffer never has an item in flight
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !s1_valid)
    else $error("item in flight with full output buffer");

  // An empty buffer always takes items
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !item_stall)
    else $error("stall with empty output buffer");

endmodule

// ===== dv/relocation_record_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// relocation_record_decoder_top_tb
// Self-checking bench for the relocation record decoder. The import table is
// loaded first. A short directed sequence covers the extremes, and then
// register settings change phase by phase. Each phase sends sections of
// random well-formed records, with noise bytes, table loads and restarts
// mixed in. A shadow decoder predicts every patch and error result. Results
// are compared in order, field by field. Both sides idle and stall at
// random, and now and then the receiver holds off long enough to back the
// block up into its input.
// ----------------------------------------------------------------------------
module relocation_record_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrd_pkg::*;

  // Record header codes
  localparam logic [1:0]  KIND_NONE    = 2'd0;
  localparam logic [1:0]  KIND_SECTION = 2'd1;
  localparam logic [1:0]  KIND_SYMBOL  = 2'd2;
  localparam logic [3:0]  TYPE_NONE    = 4'd0;
  localparam logic [3:0]  TYPE_FIRST   = 4'd4;
  localparam logic [3:0]  TYPE_LAST    = 4'd9;
  localparam logic [28:0] SEC_DATA     = 29'd1;
  localparam logic [28:0] SEC_SYMBOL   = 29'd2;
  localparam logic [28:0] SEC_CODE     = 29'd3;
  localparam logic [1:0]  ACT_NOP      = 2'd3;

  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 200;
  localparam int HOLD_SPACING = 1000;
  localparam int RANDOM_ITEMS = 1100;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  in_item_t          item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  out_item_t         result;
  logic              cfg_write = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  relocation_record_decoder_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow decoder
  // --------------------------------------------------------------------------
  typedef enum logic [2:0] {P_HDR, P_NUM1, P_NUM2, P_NUM3, P_NUM4, P_DELTA} parse_step_t;

  parse_step_t step_m;
  logic [7:0]  hdr_m;
  logic [28:0] num_m;
  logic [1:0]  left_m;
  logic [31:0] delta_m;
  logic [31:0] loc_m;
  logic [31:0] target_m;
  logic [15:0] records_m;
  logic        halt_m;
  logic [31:0] imports_m [IMPORT_DEPTH];
  cfg_t        regs_m;

  in_item_t    stream_q[$];
  out_item_t   expected_patches[$];
  int unsigned counted_items;
  int unsigned mismatches;

  function automatic void clear_parse();
    step_m   = P_HDR;
    hdr_m    = '0;
    num_m    = '0;
    left_m   = '0;
    delta_m  = '0;
    target_m = '0;
  endfunction

  // Error result: zero patch, last flag set, decoder halts
  function automatic out_item_t error_result(input logic [2:0] code);
    out_item_t r;
    r = '0;
    r.status = code;
    r.last_record = 1'b1;
    halt_m = 1'b1;
    clear_parse();
    return r;
  endfunction

  // Item number complete: pick the target, or report a bad item or kind
  function automatic bit resolve_target(output out_item_t r);
    r = '0;
    case (hdr_m[3:2])
      KIND_SECTION: begin
        case (num_m)
          SEC_DATA:   target_m = regs_m.data_address;
          SEC_SYMBOL: target_m = regs_m.symbol_address;
          SEC_CODE:   target_m = regs_m.code_address;
          default: begin
            r = error_result(ST_BAD_SECTION);
            return 1'b1;
          end
        endcase
      end
      KIND_SYMBOL: begin
        if (num_m == 0 || num_m > 29'(regs_m.import_count) || num_m > IMPORT_DEPTH) begin
          r = error_result(ST_BAD_SYMBOL);
          return 1'b1;
        end
        target_m = imports_m[8'(num_m - 29'd1)];
      end
      default: begin
        r = error_result(ST_BAD_KIND);
        return 1'b1;
      end
    endcase
    step_m  = P_DELTA;
    left_m  = hdr_m[1:0];
    delta_m = '0;
    return 1'b0;
  endfunction

  // Advance the shadow by one transfer; returns 1 when a result is due
  function automatic bit predict_patch(input in_item_t it, output out_item_t r);
    logic [31:0] addend;
    logic [3:0]  rtype;
    logic [1:0]  width;
    logic [1:0]  lane;
    r = '0;
    case (it.action)
      ACT_BYTE: begin
        if (halt_m || records_m >= regs_m.record_count) return 1'b0;
        case (step_m)
          P_HDR: begin
            hdr_m  = it.stream_byte;
            step_m = P_NUM1;
          end
          P_NUM1: begin
            if (it.stream_byte[7]) begin
              num_m  = 29'(it.stream_byte[6:0]);
              step_m = P_NUM2;
            end else begin
              num_m = 29'(it.stream_byte);
              return resolve_target(r);
            end
          end
          P_NUM2: begin
            num_m = 29'({num_m, it.stream_byte});
            if (num_m[14]) begin
              num_m  = num_m & 29'h3FFF;
              step_m = P_NUM3;
            end else begin
              return resolve_target(r);
            end
          end
          P_NUM3: begin
            num_m = 29'({num_m, it.stream_byte});
            if (num_m[21]) begin
              num_m  = num_m & 29'h1F_FFFF;
              step_m = P_NUM4;
            end else begin
              return resolve_target(r);
            end
          end
          P_NUM4: begin
            num_m = 29'({num_m, it.stream_byte});
            return resolve_target(r);
          end
          P_DELTA: begin
            // little-endian delta, first byte in the low lane
            lane    = hdr_m[1:0] - left_m;
            delta_m = delta_m | (32'(it.stream_byte) << (8 * lane));
            if (left_m != 0) begin
              left_m = left_m - 2'd1;
              return 1'b0;
            end
            // location moves even when the type turns out bad
            loc_m = loc_m + delta_m;
            rtype = hdr_m[7:4];
            if (rtype < TYPE_FIRST || rtype > TYPE_LAST) begin
              r = error_result(ST_BAD_TYPE);
              return 1'b1;
            end
            width  = 2'((rtype - TYPE_FIRST) >> 1);
            addend = target_m;
            if (rtype[0]) addend = addend - (loc_m + regs_m.section_base);
            if (width == PW_8) addend = addend & 32'hFF;
            else if (width == PW_16) addend = addend & 32'hFFFF;
            records_m       = records_m + 16'd1;
            r.patch_offset  = loc_m;
            r.patch_width   = width;
            r.patch_addend  = addend;
            r.status        = ST_OK;
            r.last_record   = (records_m >= regs_m.record_count);
            clear_parse();
            return 1'b1;
          end
          default: clear_parse();
        endcase
      end
      ACT_IMPORT: imports_m[it.import_slot] = it.import_value;
      ACT_RESTART: begin
        clear_parse();
        loc_m     = '0;
        records_m = '0;
        halt_m    = 1'b0;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: one transfer per accepted item, random gaps between items
  // --------------------------------------------------------------------------
  int gap_left;
  bit send_burst;

  always @(posedge clk) begin : driver
    out_item_t patch;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        if (predict_patch(item, patch)) expected_patches.push_back(patch);
      end
      if (!item_valid || !item_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          item_valid <= 1'b0;
        end else if (stream_q.size() != 0) begin
          item <= stream_q.pop_front();
          item_valid <= 1'b1;
          if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
          gap_left = send_burst ? 0 : $urandom_range(0, 7);
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and receiver stall
  // --------------------------------------------------------------------------
  int          wait_left;
  int          hold_left;
  int          since_hold;
  bit          take_burst;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // long hold-off now and then, while items and results are both pending,
  // so the output buffer fills and the input stalls
  always @(posedge clk) begin : holdoff
    if (rst) begin
      hold_left  <= 0;
      since_hold <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (since_hold >= HOLD_SPACING && result_valid && item_valid) begin
      hold_left  <= LONG_HOLD;
      since_hold <= 0;
    end else begin
      since_hold <= since_hold + 1;
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_patches.size() == 0) begin
          $error("unexpected result: offset %0h status %0d", result.patch_offset,
                 result.status);
          mismatches++;
        end else begin
          want = expected_patches.pop_front();
          check_field("patch_offset", want.patch_offset, result.patch_offset);
          check_field("patch_width", 32'(want.patch_width), 32'(result.patch_width));
          check_field("patch_addend", want.patch_addend, result.patch_addend);
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("last_record", 32'(want.last_record), 32'(result.last_record));
        end
        if ($urandom_range(0, 39) == 0) take_burst = !take_burst;
        wait_left = take_burst ? 0 : $urandom_range(0, 7);
      end else begin
        if (wait_left != 0) wait_left--;
      end
      result_stall <= (wait_left != 0) || (hold_left != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic [1:0] act, input logic [7:0] b,
                            input logic [7:0] slot, input logic [31:0] val);
    in_item_t it;
    it.action       = act;
    it.stream_byte  = b;
    it.import_slot  = slot;
    it.import_value = val;
    stream_q.push_back(it);
    counted_items++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_item(ACT_BYTE, b, 8'($urandom), $urandom);
  endtask

  // Header, item number in len bytes (continuation coded), then size+1 delta bytes
  task automatic queue_record(input logic [3:0] rtype, input logic [1:0] kind,
                              input logic [1:0] size, input int len,
                              input logic [28:0] num, input logic [31:0] delta);
    queue_byte({rtype, kind, size});
    case (len)
      1: queue_byte({1'b0, num[6:0]});
      2: begin
        queue_byte({2'b10, num[13:8]});
        queue_byte(num[7:0]);
      end
      3: begin
        queue_byte({3'b110, num[20:16]});
        queue_byte(num[15:8]);
        queue_byte(num[7:0]);
      end
      default: begin
        queue_byte({3'b111, num[28:24]});
        queue_byte(num[23:16]);
        queue_byte(num[15:8]);
        queue_byte(num[7:0]);
      end
    endcase
    for (int i = 0; i <= size; i++) queue_byte(delta[8*i +: 8]);
  endtask

  // Mostly valid records; a few bad types, kinds and item numbers
  task automatic queue_random_record();
    logic [3:0]  rtype;
    logic [1:0]  kind;
    logic [28:0] num;
    int          len;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 90) rtype = 4'($urandom_range(TYPE_FIRST, TYPE_LAST));
    else rtype = 4'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 45) kind = KIND_SECTION;
    else if (roll < 90) kind = KIND_SYMBOL;
    else kind = 2'($urandom);
    roll = $urandom_range(0, 99);
    if (kind == KIND_SECTION && roll < 90)
      num = 29'($urandom_range(SEC_DATA, SEC_CODE));
    else if (kind == KIND_SYMBOL && regs_m.import_count != 0 && roll < 90)
      num = 29'($urandom_range(1, regs_m.import_count));
    else if (roll < 93) num = '0;
    else if (roll < 96) num = 29'(regs_m.import_count) + 29'd1;
    else num = 29'($urandom);
    if (num < 29'h80) len = 1;
    else if (num < 29'h4000) len = 2;
    else if (num < 29'h20_0000) len = 3;
    else len = 4;
    // longer-than-needed encodings are legal too
    if ($urandom_range(0, 3) == 0) len = $urandom_range(len, 4);
    queue_record(rtype, kind, 2'($urandom), len, num, $urandom);
  endtask

  // One section: restart, then records with table loads, noise and restarts mixed in
  task automatic queue_section(input int records);
    int roll;
    queue_item(ACT_RESTART, 8'($urandom), 8'($urandom), $urandom);
    repeat (records) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) queue_item(ACT_IMPORT, 8'($urandom), 8'($urandom), $urandom);
      else if (roll < 8) repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      else if (roll < 9) queue_item(ACT_NOP, 8'($urandom), 8'($urandom), $urandom);
      else if (roll < 10) queue_item(ACT_RESTART, 8'($urandom), 8'($urandom), $urandom);
      queue_random_record();
    end
  endtask

  // Wait until every item is taken and every result is back, then let the pipe drain
  task automatic wait_drained();
    @(negedge clk);
    while (stream_q.size() != 0 || item_valid || expected_patches.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic load_registers(input cfg_t c);
    wait_drained();
    write_reg(REG_DATA_ADDRESS, c.data_address);
    write_reg(REG_SYMBOL_ADDRESS, c.symbol_address);
    write_reg(REG_CODE_ADDRESS, c.code_address);
    write_reg(REG_SECTION_BASE, c.section_base);
    write_reg(REG_IMPORT_COUNT, 32'(c.import_count));
    write_reg(REG_RECORD_COUNT, 32'(c.record_count));
    @(posedge clk);
    cfg_write <= 1'b0;
    regs_m = c;
    @(negedge clk);
  endtask

  function automatic cfg_t random_regs(input int mode);
    cfg_t c;
    c = '0;
    case (mode)
      0: begin
        c.data_address   = $urandom;
        c.symbol_address = $urandom;
        c.code_address   = $urandom;
        c.section_base   = $urandom;
        c.import_count   = 9'($urandom_range(0, IMPORT_DEPTH));
        c.record_count   = 16'($urandom_range(1, 16));
      end
      1: begin
        c.data_address   = '1;
        c.symbol_address = '1;
        c.code_address   = '1;
        c.section_base   = '1;
        c.import_count   = 9'(IMPORT_DEPTH);
        c.record_count   = '1;
      end
      2: ;  // everything zero: no records expected at all
      3: c.record_count = 16'($urandom_range(1, 8));
      default: begin
        c.data_address   = $urandom;
        c.symbol_address = $urandom;
        c.code_address   = $urandom;
        c.section_base   = $urandom;
        c.import_count   = 9'($urandom_range(1, 4));
        c.record_count   = 16'($urandom_range(1, 3));
      end
    endcase
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    int   phase;
    regs_m    = '0;
    loc_m     = '0;
    records_m = '0;
    halt_m    = 1'b0;
    clear_parse();
    foreach (imports_m[i]) imports_m[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill the whole import table so no record reads an empty entry
    for (int s = 0; s < IMPORT_DEPTH; s++)
      queue_item(ACT_IMPORT, 8'($urandom), 8'(s), $urandom);

    // directed: extreme addresses, full table, two records per section
    c = '0;
    c.data_address   = 32'hFFFF_FFFF;
    c.symbol_address = 32'h0000_0001;
    c.code_address   = 32'h8000_0000;
    c.section_base   = 32'hFFFF_FFF0;
    c.import_count   = 9'(IMPORT_DEPTH);
    c.record_count   = 16'd2;
    load_registers(c);
    queue_item(ACT_NOP, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    queue_item(ACT_RESTART, 8'h00, 8'h00, 32'h0);
    // 8-bit absolute patch, one-byte delta
    queue_record(TYPE_FIRST, KIND_SECTION, 2'd0, 1, SEC_DATA, 32'hFF);
    // 32-bit relative patch from the top table entry, four-byte delta, last record
    queue_record(TYPE_LAST, KIND_SYMBOL, 2'd3, 2, 29'(IMPORT_DEPTH), 32'hFFFF_FFFF);
    // records used up: byte dropped
    queue_byte(8'hA5);
    queue_item(ACT_RESTART, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    // bad type, flagged only after the delta
    queue_record(TYPE_NONE, KIND_SECTION, 2'd0, 4, SEC_CODE, 32'h0);
    // halted: byte dropped
    queue_byte(8'h00);
    queue_item(ACT_RESTART, 8'h00, 8'h00, 32'h0);
    // bad kind
    queue_record(TYPE_FIRST, KIND_NONE, 2'd1, 3, SEC_DATA, 32'h1234);

    // random phases, each with its own register setting
    phase = 0;
    while (counted_items < RANDOM_ITEMS) begin
      load_registers(random_regs(phase % 5));
      repeat ($urandom_range(2, 5)) queue_section($urandom_range(1, 10));
      phase++;
    end

    wait_drained();
    if (mismatches == 0 && expected_patches.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("FAIL");
    $finish;
  end

endmodule
